### sv/cia_pkg.sv
`default_nettype none
package cia_pkg;

  // operation codes
  localparam logic [3:0] K_ADD = 4'd0;
  localparam logic [3:0] K_SUB = 4'd1;
  localparam logic [3:0] K_MUL = 4'd2;
  localparam logic [3:0] K_MOD = 4'd3;
  localparam logic [3:0] K_EQ  = 4'd4;
  localparam logic [3:0] K_NE  = 4'd5;
  localparam logic [3:0] K_GT  = 4'd6;
  localparam logic [3:0] K_LT  = 4'd7;
  localparam logic [3:0] K_GE  = 4'd8;
  localparam logic [3:0] K_LE  = 4'd9;
  localparam logic [3:0] K_NEG = 4'd10;
  localparam logic [3:0] K_AND = 4'd11;
  localparam logic [3:0] K_OR  = 4'd12;
  localparam logic [3:0] K_NOT = 4'd13;

  // error codes
  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_ADD_OVF = 3'd1;
  localparam logic [2:0] E_SUB_OVF = 3'd2;
  localparam logic [2:0] E_MUL_OVF = 3'd3;
  localparam logic [2:0] E_MOD_ZERO = 3'd4;
  localparam logic [2:0] E_NEG_OVF = 3'd5;

  localparam int unsigned NCELLS = 32;
  // input reg, product reg, cells, output reg
  localparam int unsigned LATENCY = NCELLS + 3;

  // transaction as it travels down the remainder chain
  typedef struct packed {
    logic        vld;
    logic [3:0]  kind;
    logic [31:0] value;
    logic [2:0]  err;
    logic        neg;
    logic [31:0] rem;
    logic [31:0] dvd;
    logic [31:0] dvs;
  } slot_t;

endpackage
`default_nettype wire

### sv/checked_int_alu_top.sv
`default_nettype none
// channel   ports                                   direction
// input     start, busy, in_kind, in_left, in_right  in (busy out)
// result    out_valid, out_value, out_error_code     out
// every operation passes from start to out_valid through the operand
// register, multiplier register, 32 remainder cells and output register.
// one transaction is taken every cycle; busy stays low.
// synchronous active-low reset empties the pipeline.
// the receiver cannot stall; results leave on a fixed schedule.
module checked_int_alu_top (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire  [3:0]        in_kind,
  input  wire  signed [31:0] in_left,
  input  wire  signed [31:0] in_right,
  output logic              out_valid,
  output logic signed [31:0] out_value,
  output logic [2:0]        out_error_code
);

  cia_pkg::slot_t chain [0:cia_pkg::NCELLS];
  logic           ov_r;
  logic [31:0]    val_r;
  logic [2:0]     err_r;
  logic [31:0]    fin_nxt;

  assign busy = 1'b0;

  cia_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (start && !busy),
    .kind   (in_kind),
    .left   (in_left),
    .right  (in_right),
    .slot_o (chain[0])
  );

  // remainder chain
  for (genvar i = 0; i < cia_pkg::NCELLS; i++) begin : g_cell
    cia_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .slot_i (chain[i]),
      .slot_o (chain[i+1])
    );
  end

  // apply remainder sign
  always_comb begin
    fin_nxt = chain[cia_pkg::NCELLS].value;
    if (chain[cia_pkg::NCELLS].kind == cia_pkg::K_MOD &&
        chain[cia_pkg::NCELLS].err == cia_pkg::E_NONE) begin
      fin_nxt = chain[cia_pkg::NCELLS].neg ? 32'd0 - chain[cia_pkg::NCELLS].rem
                                           : chain[cia_pkg::NCELLS].rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= chain[cia_pkg::NCELLS].vld;
    end
    val_r <= fin_nxt;
    err_r <= chain[cia_pkg::NCELLS].err;
  end

  assign out_valid      = ov_r;
  assign out_value      = val_r;
  assign out_error_code = err_r;

endmodule
`default_nettype wire

### sv/cia_front.sv
`default_nettype none
module cia_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 acc,
  input  wire  [3:0]          kind,
  input  wire  signed [31:0]  left,
  input  wire  signed [31:0]  right,
  output cia_pkg::slot_t      slot_o
);

  logic               v1_r;
  logic [3:0]         k1_r;
  logic signed [31:0] a1_r, b1_r;

  logic               v2_r;
  logic [3:0]         k2_r;
  logic signed [63:0] prod_r;
  logic [31:0]        val2_r;
  logic [2:0]         err2_r;
  logic               neg2_r;
  logic [31:0]        dvd2_r, dvs2_r;

  logic [31:0]        val_nxt;
  logic [2:0]         err_nxt;
  logic [32:0]        sum, dif;
  logic               lt, eq, az, bz;

  // operand register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
    k1_r <= kind;
    a1_r <= left;
    b1_r <= right;
  end

  // combinational operations on the operand register; modulo only checks for zero here
  always_comb begin
    sum = {a1_r[31], a1_r} + {b1_r[31], b1_r};
    dif = {a1_r[31], a1_r} - {b1_r[31], b1_r};
    lt  = a1_r < b1_r;
    eq  = a1_r == b1_r;
    az  = a1_r == 32'sd0;
    bz  = b1_r == 32'sd0;
    val_nxt = '0;
    err_nxt = cia_pkg::E_NONE;
    unique case (k1_r)
      cia_pkg::K_ADD: begin
        if (sum[32] != sum[31]) err_nxt = cia_pkg::E_ADD_OVF;
        else val_nxt = sum[31:0];
      end
      cia_pkg::K_SUB: begin
        if (dif[32] != dif[31]) err_nxt = cia_pkg::E_SUB_OVF;
        else val_nxt = dif[31:0];
      end
      cia_pkg::K_MOD: begin
        if (bz) err_nxt = cia_pkg::E_MOD_ZERO;
      end
      cia_pkg::K_EQ: val_nxt = {31'd0, eq};
      cia_pkg::K_NE: val_nxt = {31'd0, !eq};
      cia_pkg::K_GT: val_nxt = {31'd0, !lt && !eq};
      cia_pkg::K_LT: val_nxt = {31'd0, lt};
      cia_pkg::K_GE: val_nxt = {31'd0, !lt};
      cia_pkg::K_LE: val_nxt = {31'd0, lt || eq};
      cia_pkg::K_NEG: begin
        if (a1_r == 32'sh8000_0000) err_nxt = cia_pkg::E_NEG_OVF;
        else val_nxt = 32'd0 - a1_r;
      end
      cia_pkg::K_AND: val_nxt = {31'd0, !az && !bz};
      cia_pkg::K_OR:  val_nxt = {31'd0, !az || !bz};
      cia_pkg::K_NOT: val_nxt = {31'd0, az};
      default: val_nxt = '0;
    endcase
  end

  // product and chain setup register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    k2_r   <= k1_r;
    prod_r <= a1_r * b1_r;
    val2_r <= val_nxt;
    err2_r <= err_nxt;
    neg2_r <= a1_r[31];
    dvd2_r <= a1_r[31] ? 32'd0 - a1_r : a1_r;
    dvs2_r <= b1_r[31] ? 32'd0 - b1_r : b1_r;
  end

  // multiply overflow check, then hand off to the chain
  always_comb begin
    slot_o.vld   = v2_r;
    slot_o.kind  = k2_r;
    slot_o.value = val2_r;
    slot_o.err   = err2_r;
    if (k2_r == cia_pkg::K_MUL) begin
      if (prod_r[63:31] == {33{1'b0}} || prod_r[63:31] == {33{1'b1}}) begin
        slot_o.value = prod_r[31:0];
      end else begin
        slot_o.value = '0;
        slot_o.err   = cia_pkg::E_MUL_OVF;
      end
    end
    slot_o.neg = neg2_r;
    slot_o.rem = '0;
    slot_o.dvd = dvd2_r;
    slot_o.dvs = dvs2_r;
  end

endmodule
`default_nettype wire

### sv/cia_cell.sv
`default_nettype none
module cia_cell (
  input  wire             clk,
  input  wire             rst_n,
  input  cia_pkg::slot_t  slot_i,
  output cia_pkg::slot_t  slot_o
);

  cia_pkg::slot_t slot_r, slot_nxt;
  logic [31:0]    sh;
  logic [32:0]    diff;

  // one restoring remainder step
  always_comb begin
    sh   = {slot_i.rem[30:0], slot_i.dvd[31]};
    diff = {1'b0, sh} - {1'b0, slot_i.dvs};
    slot_nxt     = slot_i;
    slot_nxt.dvd = {slot_i.dvd[30:0], 1'b0};
    slot_nxt.rem = diff[32] ? sh : diff[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else begin
      slot_r.vld <= slot_nxt.vld;
    end
    slot_r.kind  <= slot_nxt.kind;
    slot_r.value <= slot_nxt.value;
    slot_r.err   <= slot_nxt.err;
    slot_r.neg   <= slot_nxt.neg;
    slot_r.rem   <= slot_nxt.rem;
    slot_r.dvd   <= slot_nxt.dvd;
    slot_r.dvs   <= slot_nxt.dvs;
  end

  assign slot_o = slot_r;

endmodule
`default_nettype wire

### sv/cia_checker.sv
`default_nettype none
module cia_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               start,
  input wire               busy,
  input wire               out_valid,
  input wire signed [31:0] out_value,
  input wire [2:0]         out_error_code
);

  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##35 out_valid)
    else $error("result missing after accepted transaction");

  // an error always zeroes the value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != 3'd0) |-> out_value == 32'sd0)
    else $error("nonzero value with error");

  // only defined error codes appear
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code <= 3'd5)
    else $error("undefined error code");

endmodule

bind checked_int_alu_top cia_checker u_cia_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_value      (out_value),
  .out_error_code (out_error_code)
);
`default_nettype wire
